FILE: hw/rtl/jsba_pkg.sv
// shared types, constants and key compare for the job sort-by-arrival unit
`timescale 1ns / 1ps

package jsba_pkg;

    localparam int MaxJobsDefault = 16;

    typedef struct packed {
        logic [7:0]  job_id;
        logic [7:0]  arrival_time;
        logic [31:0] burst_time;
        logic        last_job;
    } t_job_in;

    typedef struct packed {
        logic [7:0]  out_job_id;
        logic [7:0]  out_arrival_time;
        logic [31:0] out_burst_time;
        logic        out_last;
        logic        overflowed;
    } t_job_out;

    typedef struct packed {
        logic [7:0]  job_id;
        logic [7:0]  arrival_time;
        logic [31:0] burst_time;
    } t_job_rec;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic     insert;
        logic     shift_out;
        logic     descending;
        t_job_rec new_rec;
    } t_cell_ctrl;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // true if the new key must sit in front of the stored key
    function automatic logic goes_before(input logic descending,
                                         input logic [7:0] new_key,
                                         input logic [7:0] stored_key);
        goes_before = descending ? (new_key > stored_key) : (new_key < stored_key);
    endfunction

endpackage

FILE: hw/rtl/jsba_cell.sv
// one compare-and-shift cell of the sorting chain
`timescale 1ns / 1ps

module jsba_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  jsba_pkg::t_cell_ctrl  i_ctrl,
    input  jsba_pkg::t_job_rec    i_left_rec,
    input  logic                  i_left_valid,
    input  jsba_pkg::t_job_rec    i_right_rec,
    input  logic                  i_right_valid,
    input  logic                  i_found,
    output logic                  o_found,
    output jsba_pkg::t_job_rec    o_rec,
    output logic                  o_valid
);

    jsba_pkg::t_job_rec r_rec;
    logic               r_valid;
    logic               w_hit;

    // an empty cell or a key that the new record beats marks the insert point
    assign w_hit   = !r_valid || jsba_pkg::goes_before(i_ctrl.descending,
                                                       i_ctrl.new_rec.arrival_time,
                                                       r_rec.arrival_time);
    assign o_found = i_found || w_hit;
    assign o_rec   = r_rec;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift_out) begin
            r_valid <= i_right_valid;
        end else if (i_ctrl.insert) begin
            if (i_found) begin
                r_valid <= i_left_valid;
            end else if (w_hit) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_out) begin
            r_rec <= i_right_rec;
        end else if (i_ctrl.insert) begin
            if (i_found) begin
                r_rec <= i_left_rec;
            end else if (w_hit) begin
                r_rec <= i_ctrl.new_rec;
            end
        end
    end

endmodule

FILE: hw/rtl/job_sort_by_arrival_unit.sv
// top level: batch insertion sort of job records by arrival time
//
//  channel   | ports                            | handshake
//  ----------+----------------------------------+-----------------------------------
//  job in    | start, busy, i_job               | taken when start & !busy
//  result    | o_res_strobe, o_result           | one result per strobe cycle, no stall
//  config    | i_cfg_we, i_cfg_wdata            | written when i_cfg_we
//
// loading takes one record per cycle while busy is low; each record is compared
// against all cells at once and the chain of compare-and-shift cells opens its slot
// in that cycle, unless full. after the last-job transaction, busy stays high while
// the stored records shift out of cell 0, one result per cycle, the final one marked
// out_last. synchronous reset empties the chain (valid bits only), no clearing pass
// needed. the receiver cannot stall, so a batch always drains without a gap.
`timescale 1ns / 1ps

module job_sort_by_arrival_unit #(
    parameter int MAX_JOBS = jsba_pkg::MaxJobsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  jsba_pkg::t_job_in  i_job,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output logic               o_res_strobe,
    output jsba_pkg::t_job_out o_result
);

    jsba_pkg::t_state     r_state;
    jsba_pkg::t_state     n_state;
    logic                 r_descending;
    logic                 r_drop;
    logic                 w_accept;
    logic                 w_full;
    jsba_pkg::t_cell_ctrl w_ctrl;

    jsba_pkg::t_job_rec   w_rec   [MAX_JOBS];
    logic                 w_valid [MAX_JOBS];
    logic                 w_found [MAX_JOBS+1];

    assign busy     = (r_state == jsba_pkg::ST_EMIT);
    assign w_accept = start && !busy;
    assign w_full   = w_valid[MAX_JOBS-1];

    assign w_ctrl.insert           = w_accept && !w_full;
    assign w_ctrl.shift_out        = busy;
    assign w_ctrl.descending       = r_descending;
    assign w_ctrl.new_rec.job_id       = i_job.job_id;
    assign w_ctrl.new_rec.arrival_time = i_job.arrival_time;
    assign w_ctrl.new_rec.burst_time   = i_job.burst_time;

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        jsba_pkg::t_job_rec w_left_rec;
        jsba_pkg::t_job_rec w_right_rec;
        logic               w_left_valid;
        logic               w_right_valid;

        if (g == 0) begin : g_first
            assign w_left_rec   = '0;
            assign w_left_valid = 1'b0;
        end else begin : g_mid_l
            assign w_left_rec   = w_rec[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == MAX_JOBS - 1) begin : g_last
            assign w_right_rec   = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_mid_r
            assign w_right_rec   = w_rec[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        jsba_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left_rec    (w_left_rec),
            .i_left_valid  (w_left_valid),
            .i_right_rec   (w_right_rec),
            .i_right_valid (w_right_valid),
            .i_found       (w_found[g]),
            .o_found       (w_found[g+1]),
            .o_rec         (w_rec[g]),
            .o_valid       (w_valid[g])
        );
    end

    // chain end carry is only a by-product of the insert search
    logic w_unused_found;
    assign w_unused_found = w_found[MAX_JOBS];

    // results come straight from the head cell
    assign o_res_strobe                = busy && w_valid[0];
    assign o_result.out_job_id         = w_rec[0].job_id;
    assign o_result.out_arrival_time   = w_rec[0].arrival_time;
    assign o_result.out_burst_time     = w_rec[0].burst_time;
    assign o_result.out_last           = !w_valid[1];
    assign o_result.overflowed         = r_drop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jsba_pkg::ST_LOAD: begin
                if (w_accept && i_job.last_job) begin
                    n_state = jsba_pkg::ST_EMIT;
                end
            end
            jsba_pkg::ST_EMIT: begin
                if (!w_valid[1]) begin
                    n_state = jsba_pkg::ST_LOAD;
                end
            end
            default: n_state = jsba_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jsba_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop <= 1'b0;
        end else if (busy && !w_valid[1]) begin
            r_drop <= 1'b0;
        end else if (w_accept && w_full) begin
            r_drop <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending <= 1'b0;
        end else if (i_cfg_we) begin
            r_descending <= i_cfg_wdata;
        end
    end

endmodule

FILE: bench/testbench.sv
// self-checking bench for the job sort-by-arrival unit: directed batches, then random batches
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_JOBS   = jsba_pkg::MaxJobsDefault;
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 4;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    jsba_pkg::t_job_in  i_job;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               o_res_strobe;
    jsba_pkg::t_job_out o_result;

    // model of the sorted store, kept in step with accepted transactions
    jsba_pkg::t_job_rec model_store[MAX_JOBS];
    int                 model_count;
    bit                 model_dropped;
    bit                 model_descending;

    jsba_pkg::t_job_out sorted_results[$];
    int                 error_count;
    int                 sender_idle_pct;
    int                 cycle_count;

    job_sort_by_arrival_unit #(
        .MAX_JOBS(MAX_JOBS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_job       (i_job),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_strobe(o_res_strobe),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit key_ahead(input bit descending, input logic [7:0] new_key,
                                     input logic [7:0] held_key);
        if (descending) begin
            return new_key > held_key;
        end
        return new_key < held_key;
    endfunction

    // insert one record into the model; on a last-job record queue the whole sorted batch
    task automatic predict_sorted(input jsba_pkg::t_job_in job);
        int                 slot;
        bit                 found;
        jsba_pkg::t_job_out res;
        if (model_count >= MAX_JOBS) begin
            model_dropped = 1'b1;
        end else begin
            slot  = model_count;
            found = 1'b0;
            for (int i = 0; i < model_count; i++) begin
                if (!found && key_ahead(model_descending, job.arrival_time,
                                        model_store[i].arrival_time)) begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            for (int i = model_count; i > slot; i--) begin
                model_store[i] = model_store[i - 1];
            end
            model_store[slot].job_id       = job.job_id;
            model_store[slot].arrival_time = job.arrival_time;
            model_store[slot].burst_time   = job.burst_time;
            model_count++;
        end
        if (job.last_job) begin
            for (int k = 0; k < model_count; k++) begin
                res.out_job_id       = model_store[k].job_id;
                res.out_arrival_time = model_store[k].arrival_time;
                res.out_burst_time   = model_store[k].burst_time;
                res.out_last         = (k + 1 == model_count);
                res.overflowed       = model_dropped;
                sorted_results       = {sorted_results, res};
            end
            model_count   = 0;
            model_dropped = 1'b0;
        end
    endtask

    // one transaction: optional idle gap, then hold start until busy is low at an edge
    task automatic send_job(input jsba_pkg::t_job_in job);
        int gap;
        gap = 0;
        while (gap < 64 && $urandom_range(99, 0) < sender_idle_pct) begin
            gap++;
        end
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_job <= job;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_sorted(job);
    endtask

    // lower start and wait until every queued result has been seen
    task automatic wait_results_drained;
        @(negedge i_clk);
        start <= 1'b0;
        while (sorted_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_order(input bit descending);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= descending;
        @(posedge i_clk);
        model_descending = descending;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic jsba_pkg::t_job_in make_job(input logic [7:0] id,
                                                   input logic [7:0] arrival,
                                                   input logic [31:0] burst, input bit last);
        jsba_pkg::t_job_in job;
        job.job_id       = id;
        job.arrival_time = arrival;
        job.burst_time   = burst;
        job.last_job     = last;
        return job;
    endfunction

    function automatic jsba_pkg::t_job_in random_job(input bit last);
        logic [7:0] arrival;
        // small key range half the time so ties are common
        arrival = ($urandom_range(1, 0) == 0) ? 8'($urandom_range(3, 0))
                                              : 8'($urandom_range(255, 0));
        return make_job(8'($urandom), arrival, $urandom, last);
    endfunction

    // field extremes and ties, ascending order
    task automatic test_extremes;
        set_order(1'b0);
        send_job(make_job(8'hff, 8'hff, 32'hffff_ffff, 1'b0));
        send_job(make_job(8'h00, 8'h00, 32'h0000_0000, 1'b0));
        send_job(make_job(8'h5a, 8'hff, 32'ha5a5_a5a5, 1'b0));
        send_job(make_job(8'ha5, 8'h00, 32'h5a5a_5a5a, 1'b1));
    endtask

    task automatic test_single_record;
        set_order(1'b1);
        send_job(make_job(8'h11, 8'h80, 32'h1234_5678, 1'b1));
    endtask

    // records already stored keep their place when the order flips
    task automatic test_order_change_mid_batch;
        set_order(1'b0);
        send_job(make_job(8'h01, 8'h40, 32'h0000_0001, 1'b0));
        send_job(make_job(8'h02, 8'h20, 32'h0000_0002, 1'b0));
        set_order(1'b1);
        send_job(make_job(8'h03, 8'h30, 32'h0000_0003, 1'b1));
    endtask

    // full store, then the last-job record itself is dropped
    task automatic test_overflow_last_dropped;
        set_order(1'b0);
        for (int i = 0; i < MAX_JOBS; i++) begin
            send_job(random_job(1'b0));
        end
        send_job(random_job(1'b1));
    endtask

    task automatic test_random_batches(input int idle_pct, input int item_goal);
        int sent;
        int batch_len;
        sender_idle_pct = idle_pct;
        sent = 0;
        set_order(1'b1);
        while (sent < item_goal) begin
            if ($urandom_range(2, 0) == 0) begin
                set_order(1'($urandom_range(1, 0)));
            end
            // mostly small batches, now and then one near or past capacity
            batch_len = ($urandom_range(7, 0) == 0) ? $urandom_range(MAX_JOBS + 6, MAX_JOBS - 2)
                                                    : $urandom_range(6, 1);
            for (int i = 0; i < batch_len; i++) begin
                send_job(random_job(i == batch_len - 1));
            end
            sent += batch_len;
        end
    endtask

    // compare each result transaction against the oldest expectation
    always @(posedge i_clk) begin : result_check
        jsba_pkg::t_job_out exp_res;
        if (i_rst_n && o_res_strobe === 1'b1) begin
            if (sorted_results.size() == 0) begin
                $error("unexpected result: job id %0d", o_result.out_job_id);
                error_count++;
            end else begin
                exp_res = sorted_results.pop_front();
                if (o_result.out_job_id !== exp_res.out_job_id) begin
                    $error("out_job_id: expected %0d, actual %0d",
                           exp_res.out_job_id, o_result.out_job_id);
                    error_count++;
                end
                if (o_result.out_arrival_time !== exp_res.out_arrival_time) begin
                    $error("out_arrival_time: expected %0d, actual %0d",
                           exp_res.out_arrival_time, o_result.out_arrival_time);
                    error_count++;
                end
                if (o_result.out_burst_time !== exp_res.out_burst_time) begin
                    $error("out_burst_time: expected %0h, actual %0h",
                           exp_res.out_burst_time, o_result.out_burst_time);
                    error_count++;
                end
                if (o_result.out_last !== exp_res.out_last) begin
                    $error("out_last: expected %0b, actual %0b",
                           exp_res.out_last, o_result.out_last);
                    error_count++;
                end
                if (o_result.overflowed !== exp_res.overflowed) begin
                    $error("overflowed: expected %0b, actual %0b",
                           exp_res.overflowed, o_result.overflowed);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_job            = '0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 1'b0;
        model_count      = 0;
        model_dropped    = 1'b0;
        model_descending = 1'b0;
        error_count      = 0;
        sender_idle_pct  = 26;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_single_record();
        test_order_change_mid_batch();
        test_overflow_last_dropped();
        test_random_batches(26, 30);
        test_random_batches(80, 30);
        test_random_batches(0, 30);

        wait_results_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/jsba_pkg.sv
hw/rtl/jsba_cell.sv
hw/rtl/job_sort_by_arrival_unit.sv
bench/testbench.sv
